// ===== design/ffap_pkg.sv =====
// Constants, types and helper functions for the fixed-field ASCII frame parser.
package ffap_pkg;

  localparam logic [7:0] START_BYTE = 8'h19;
  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(16);

  localparam int unsigned BALL_W = 10;
  localparam int unsigned SCORE_W = 4;
  localparam int unsigned TOTAL_W = 14;

  localparam logic RESULT_OK = 1'b0;
  localparam logic RESULT_ERROR = 1'b1;

  localparam logic [1:0] FIELD_BALL = 2'd0;
  localparam logic [1:0] FIELD_SCORE = 2'd1;
  localparam logic [1:0] FIELD_TOTAL_FIRST = 2'd2;
  localparam logic [1:0] FIELD_TOTAL_SECOND = 2'd3;

  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
  } field_sel_t;

  // Maps a byte position within the frame to the field it belongs to.
  function automatic field_sel_t field_of(input logic [POS_W-1:0] pos);
    field_sel_t sel;
    sel.hit = 1'b1;
    sel.idx = FIELD_BALL;
    priority if (pos >= POS_W'(1) && pos <= POS_W'(3)) begin
      sel.idx = FIELD_BALL;
    end else if (pos == POS_W'(5)) begin
      sel.idx = FIELD_SCORE;
    end else if (pos >= POS_W'(7) && pos <= POS_W'(10)) begin
      sel.idx = FIELD_TOTAL_FIRST;
    end else if (pos >= POS_W'(13) && pos <= POS_W'(16)) begin
      sel.idx = FIELD_TOTAL_SECOND;
    end else begin
      sel.hit = 1'b0;
    end
    return sel;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Shifts one decimal digit into an accumulated value.
  function automatic logic [TOTAL_W-1:0] add_digit(input logic [TOTAL_W-1:0] v,
                                                   input logic [3:0] d);
    return (v << 3) + (v << 1) + TOTAL_W'(d);
  endfunction

endpackage

// ===== design/fixed_field_ascii_frame_parser.sv =====
// A result is registered and presented in the cycle after the request that causes it is accepted.
// Throughput: one byte request per cycle; the output register lets a new byte in while
// a finished result waits, and the byte is held off only when that result is not taken.
// Reset: rst clears the open frame, the position counter and the output valid flag;
// field accumulators are cleared whenever a start byte opens a frame.
// Digit checks and decimal accumulation run one byte at a time in a single stage.
module fixed_field_ascii_frame_parser
  import ffap_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               result_kind,
  output logic [BALL_W-1:0]  ball_count,
  output logic [SCORE_W-1:0] single_score,
  output logic [TOTAL_W-1:0] total_first,
  output logic [TOTAL_W-1:0] total_second
);

  logic               frame_open, frame_open_next;
  logic [POS_W-1:0]   byte_position, byte_position_next;
  logic [TOTAL_W-1:0] acc [4];
  logic [TOTAL_W-1:0] acc_next [4];
  logic [3:0]         ended, ended_next;
  logic               err, err_next;

  logic               accept;
  logic               res_load;
  logic               res_kind_next;
  field_sel_t         sel;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;
  assign sel = field_of(byte_position + POS_W'(1));

  always_comb begin
    frame_open_next = frame_open;
    byte_position_next = byte_position;
    acc_next = acc;
    ended_next = ended;
    err_next = err;
    res_load = 1'b0;
    res_kind_next = RESULT_OK;
    if (accept) begin
      if (rx_byte == START_BYTE) begin
        frame_open_next = 1'b1;
        byte_position_next = '0;
        acc_next[FIELD_BALL] = '0;
        acc_next[FIELD_SCORE] = '0;
        acc_next[FIELD_TOTAL_FIRST] = '0;
        acc_next[FIELD_TOTAL_SECOND] = '0;
        ended_next = '0;
        err_next = 1'b0;
        if (frame_open) begin
          res_load = 1'b1;
          res_kind_next = RESULT_ERROR;
        end
      end else if (frame_open) begin
        byte_position_next = byte_position + POS_W'(1);
        if (sel.hit && !ended[sel.idx]) begin
          if (rx_byte == 8'h00) begin
            ended_next[sel.idx] = 1'b1;
          end else if (is_digit(rx_byte)) begin
            acc_next[sel.idx] = add_digit(acc[sel.idx], rx_byte[3:0]);
          end else begin
            err_next = 1'b1;
          end
        end
        if (byte_position_next == LAST_POS) begin
          res_load = 1'b1;
          res_kind_next = err_next ? RESULT_ERROR : RESULT_OK;
          frame_open_next = 1'b0;
          byte_position_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      byte_position <= '0;
      out_valid <= 1'b0;
    end else begin
      frame_open <= frame_open_next;
      byte_position <= byte_position_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    ended <= ended_next;
    err <= err_next;
    if (res_load) begin
      result_kind <= res_kind_next;
      if (res_kind_next == RESULT_ERROR) begin
        ball_count <= '0;
        single_score <= '0;
        total_first <= '0;
        total_second <= '0;
      end else begin
        ball_count <= acc_next[FIELD_BALL][BALL_W-1:0];
        single_score <= acc_next[FIELD_SCORE][SCORE_W-1:0];
        total_first <= acc_next[FIELD_TOTAL_FIRST];
        total_second <= acc_next[FIELD_TOTAL_SECOND];
      end
    end
  end

  // An error result carries all-zero field values.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == RESULT_ERROR) |->
      (ball_count == '0) && (single_score == '0) &&
      (total_first == '0) && (total_second == '0))
    else $error("error result with nonzero fields");

  // A closed frame always has its position counter at zero.
  assert property (@(posedge clk) disable iff (rst)
    !frame_open |-> (byte_position == '0))
    else $error("position counter nonzero outside a frame");

  // The position counter never runs past the last byte of a frame.
  assert property (@(posedge clk) disable iff (rst)
    byte_position < LAST_POS)
    else $error("position counter past end of frame");

  // The last byte of a frame yields a result and closes the frame.
  assert property (@(posedge clk) disable iff (rst)
    accept && frame_open && (rx_byte != START_BYTE) &&
      (byte_position == LAST_POS - POS_W'(1)) |=> out_valid && !frame_open)
    else $error("no result after last frame byte");

  // A start byte inside an open frame yields an error result and reopens the frame.
  assert property (@(posedge clk) disable iff (rst)
    accept && frame_open && (rx_byte == START_BYTE) |=>
      out_valid && (result_kind == RESULT_ERROR) && frame_open)
    else $error("restart inside frame not reported");

endmodule

// ===== tb/tb_fixed_field_ascii_frame_parser.sv =====
// Self-checking testbench for the fixed-field ASCII frame parser: directed frames, then random byte streams under handshake stress.
module tb_fixed_field_ascii_frame_parser;
  import ffap_pkg::*;

  typedef struct packed {
    logic               kind;
    logic [BALL_W-1:0]  ball;
    logic [SCORE_W-1:0] score;
    logic [TOTAL_W-1:0] tot_a;
    logic [TOTAL_W-1:0] tot_b;
  } frame_result_t;

  typedef struct {
    logic [7:0]    rx;
    bit            typed;
    bit            has_res;
    frame_result_t res;
  } byte_row_t;

  localparam int NUM_CHARS = 12;
  localparam int NUM_PHASES = 5;
  localparam int PRESSURE_PHASE = 4;
  localparam int PHASE_ITEMS = 140;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 20;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               result_kind;
  logic [BALL_W-1:0]  ball_count;
  logic [SCORE_W-1:0] single_score;
  logic [TOTAL_W-1:0] total_first;
  logic [TOTAL_W-1:0] total_second;

  fixed_field_ascii_frame_parser u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .ball_count  (ball_count),
    .single_score(single_score),
    .total_first (total_first),
    .total_second(total_second)
  );

  bit            frm_open;
  logic [4:0]    frm_pos;
  logic [7:0]    frm_chars [NUM_CHARS];

  frame_result_t results_due [$];
  frame_result_t got_exp;
  byte_row_t     dir_table [$];
  logic [7:0]    chunk [$];

  int errors = 0;
  int n_bytes = 0;
  int n_useful = 0;
  int n_ok = 0;
  int n_err = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int send_idle [NUM_PHASES] = '{0, 58, 0, 7, 0};
  int recv_stall [NUM_PHASES] = '{0, 0, 58, 7, 0};

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d results still due", $time, results_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void clear_frame();
    frm_open = 1'b0;
    frm_pos = '0;
    foreach (frm_chars[i]) frm_chars[i] = 8'h00;
  endfunction

  function automatic bit decode_digits(input int base, input int len,
                                       output logic [TOTAL_W-1:0] val);
    logic [7:0] c;
    val = '0;
    for (int i = 0; i < len; i++) begin
      c = frm_chars[4'(base + i)];
      if (c == 8'h00) break;
      if (c < 8'h30 || c > 8'h39) return 1'b0;
      val = TOTAL_W'(val * 10) + TOTAL_W'(c - 8'h30);
    end
    return 1'b1;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output frame_result_t r);
    logic [TOTAL_W-1:0] v_ball, v_score, v_a, v_b;
    bit was_open, ok;
    r = '0;
    r.kind = RESULT_ERROR;
    if (b == START_BYTE) begin
      was_open = frm_open;
      clear_frame();
      frm_open = 1'b1;
      return was_open;
    end
    if (!frm_open) return 1'b0;
    frm_pos = frm_pos + 5'd1;
    if (frm_pos >= 1 && frm_pos <= 3) frm_chars[4'(frm_pos - 5'd1)] = b;
    else if (frm_pos == 5) frm_chars[3] = b;
    else if (frm_pos >= 7 && frm_pos <= 10) frm_chars[4'(frm_pos - 5'd3)] = b;
    else if (frm_pos >= 13 && frm_pos <= 16) frm_chars[4'(frm_pos - 5'd5)] = b;
    if (frm_pos != LAST_POS) return 1'b0;
    ok = decode_digits(0, 3, v_ball) & decode_digits(3, 1, v_score) &
         decode_digits(4, 4, v_a) & decode_digits(8, 4, v_b);
    clear_frame();
    if (ok) begin
      r.kind = RESULT_OK;
      r.ball = BALL_W'(v_ball);
      r.score = SCORE_W'(v_score);
      r.tot_a = v_a;
      r.tot_b = v_b;
    end
    return 1'b1;
  endfunction

  function automatic void add_row(input logic [7:0] b, input bit typed, input bit has_res,
                                  input frame_result_t r);
    byte_row_t row;
    row.rx = b;
    row.typed = typed;
    row.has_res = has_res;
    row.res = r;
    dir_table.push_back(row);
  endfunction

  // A tilde in the body stands for a zero byte; only the closing byte may carry a typed result.
  function automatic void add_body(input string s, input bit typed, input frame_result_t r);
    for (int i = 0; i < s.len(); i++) begin
      add_row((s[i] == "~") ? 8'h00 : 8'(s[i]), typed && (i == s.len() - 1), 1'b1, r);
    end
  endfunction

  function automatic logic [7:0] field_char(input int bad_pct);
    int r;
    r = $urandom_range(99);
    if (r < bad_pct) return 8'($urandom);
    if (r < bad_pct + 8) return 8'h00;
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  // Mostly whole frames with random digits; the rest is truncated frames, noisy fields and stray bytes.
  function automatic void make_chunk();
    int kind, len;
    chunk.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      len = $urandom_range(4, 1);
      repeat (len) chunk.push_back(8'($urandom));
    end else begin
      chunk.push_back(START_BYTE);
      len = (kind < 24) ? $urandom_range(15) : 16;
      for (int p = 1; p <= len; p++) begin
        if (p <= 3 || p == 5 || (p >= 7 && p <= 10) || p >= 13) begin
          chunk.push_back(field_char((kind < 36) ? 30 : 2));
        end else begin
          chunk.push_back(8'($urandom));
        end
      end
    end
  endfunction

  task automatic send_byte(input byte_row_t row, input int idle_pct);
    frame_result_t r;
    bit has;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      rx_byte <= 8'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= row.rx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (frm_open || row.rx == START_BYTE) n_useful++;
    has = parse_byte(row.rx, r);
    if (row.typed) begin
      has = row.has_res;
      r = row.res;
    end
    if (has) results_due.push_back(r);
    n_bytes++;
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (result_kind == RESULT_OK) n_ok++;
      else n_err++;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind=%0d %0d %0d %0d %0d",
                 $time, result_kind, ball_count, single_score, total_first, total_second);
      end else begin
        got_exp = results_due.pop_front();
        check_field("result_kind", got_exp.kind, result_kind);
        check_field("ball_count", got_exp.ball, ball_count);
        check_field("single_score", got_exp.score, single_score);
        check_field("total_first", got_exp.tot_a, total_first);
        check_field("total_second", got_exp.tot_b, total_second);
      end
    end
  end

  initial begin
    frame_result_t err_res, max_res, none;
    byte_row_t row;
    int target;
    none = '0;
    err_res = '0;
    err_res.kind = RESULT_ERROR;
    max_res = '{RESULT_OK, BALL_W'(999), SCORE_W'(9), TOTAL_W'(9999), TOTAL_W'(9999)};
    clear_frame();

    add_row(8'hFF, 1'b1, 1'b0, none);
    add_row(8'h00, 1'b1, 1'b0, none);
    add_row(START_BYTE, 1'b1, 1'b0, none);
    add_row(START_BYTE, 1'b1, 1'b1, err_res);
    add_body("999 9 9999  9999", 1'b1, max_res);
    add_row(START_BYTE, 1'b1, 1'b0, none);
    add_body("7~/+~:0000!{12~~", 1'b0, none);
    add_row(START_BYTE, 1'b1, 1'b0, none);
    add_body("123 4 5678  901:", 1'b1, err_res);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[i]) send_byte(dir_table[i], 0);

    row.typed = 1'b0;
    row.has_res = 1'b0;
    row.res = none;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      stall_pct = recv_stall[ph];
      target = n_useful + PHASE_ITEMS;
      if (ph == PRESSURE_PHASE) begin
        hold_req = 1'b1;
        row.rx = START_BYTE;
        repeat (8) send_byte(row, 0);
      end
      while (n_useful < target) begin
        make_chunk();
        foreach (chunk[i]) begin
          row.rx = chunk[i];
          send_byte(row, send_idle[ph]);
        end
      end
    end

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes, %0d of them starts or frame bytes, across five handshake phases.",
             n_bytes, n_useful);
    $display("Checked %0d decoded frames and %0d error results, one phase under a long stall.",
             n_ok, n_err);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ffap_pkg.sv
design/fixed_field_ascii_frame_parser.sv
tb/tb_fixed_field_ascii_frame_parser.sv
